// File: rtl/core/cloud_in_cell_deposit_unit_macros.svh
// ----------------------------------------------------------------------------
// cloud in cell deposit unit assertion macros
// concurrent assertion forms for the deposit unit controller
// ----------------------------------------------------------------------------
`ifndef CLOUD_IN_CELL_DEPOSIT_UNIT_MACROS_SVH
`define CLOUD_IN_CELL_DEPOSIT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CICD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define CICD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cicd_pkg.sv
// ----------------------------------------------------------------------------
// cicd_pkg
// constants, types and control structs of the cloud in cell deposit unit
// ----------------------------------------------------------------------------
package cicd_pkg;

    localparam int GRID_BITS_X   = 6;
    localparam int GRID_BITS_Y   = 6;
    localparam int POS_FRAC_BITS = 16;
    localparam int ACC_WIDTH     = 48;

    localparam int NX         = 1 << GRID_BITS_X;
    localparam int NY         = 1 << GRID_BITS_Y;
    localparam int ROW_STRIDE = NX + 1;
    localparam int NODE_COUNT = (NX + 1) * (NY + 1);
    localparam int NODE_AW    = $clog2(NODE_COUNT);

    localparam int POS_W    = POS_FRAC_BITS + 1;
    localparam int INDEX_W  = 13;
    localparam int SHIFT_X  = POS_FRAC_BITS - GRID_BITS_X;
    localparam int SHIFT_Y  = POS_FRAC_BITS - GRID_BITS_Y;
    localparam int OFF_X_W  = SHIFT_X + 1;
    localparam int OFF_Y_W  = SHIFT_Y + 1;
    localparam int WEIGHT_W = OFF_X_W + OFF_Y_W;

    localparam logic [POS_W-1:0]     POS_ONE = {1'b1, {POS_FRAC_BITS{1'b0}}};
    localparam logic [OFF_X_W-1:0]   CELL_W  = {1'b1, {SHIFT_X{1'b0}}};
    localparam logic [OFF_Y_W-1:0]   CELL_H  = {1'b1, {SHIFT_Y{1'b0}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    localparam logic KIND_DEPOSIT = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    // corner of the cell being updated, named by x then y side
    typedef enum logic [1:0] {
        NODE_00 = 2'b00,
        NODE_10 = 2'b01,
        NODE_01 = 2'b10,
        NODE_11 = 2'b11
    } corner_t;

    typedef struct packed {
        logic    load;
        logic    clear_step;
        logic    rd_node;
        logic    wr_node;
        logic    rd_index;
        logic    out_load;
        corner_t corner;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/core/cloud_in_cell_deposit_unit.sv
// deposit: after acceptance, a read-modify-write in S_DEP_RD and S_DEP_WR, one per
//   corner node through the single mesh memory port pair; in_ready low until all are done
// read and clear: the word is read in S_RD_RD; node_sum is loaded and an in-range node
//   cleared in S_RD_WR, held there while the previous output word waits for out_ready
// reset: asynchronous; a clearing sweep over all 4225 nodes zeroes the mesh, in_ready low
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit_unit
// bilinear cloud in cell deposition onto a saturating accumulator mesh
// ----------------------------------------------------------------------------
module cloud_in_cell_deposit_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [cicd_pkg::POS_W-1:0]      pos_x,
    input  logic [cicd_pkg::POS_W-1:0]      pos_y,
    input  logic [cicd_pkg::INDEX_W-1:0]    node_index,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cicd_pkg::ACC_WIDTH-1:0]  node_sum
);

    cicd_pkg::cmd_t    cmd;
    cicd_pkg::status_t status;

    cicd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    cicd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .node_index (node_index),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .node_sum   (node_sum)
    );

endmodule

// File: rtl/core/cicd_ram.sv
// ----------------------------------------------------------------------------
// cicd_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module cicd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4225
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/cicd_datapath.sv
// ----------------------------------------------------------------------------
// cicd_datapath
// cell and offset calculation, weight multiplier, saturating accumulate,
// mesh memory and output word register
// ----------------------------------------------------------------------------
module cicd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cicd_pkg::POS_W-1:0]    pos_x,
    input  logic [cicd_pkg::POS_W-1:0]    pos_y,
    input  logic [cicd_pkg::INDEX_W-1:0]  node_index,
    input  logic                          out_ready,
    input  cicd_pkg::cmd_t                cmd,
    output cicd_pkg::status_t             status,
    output logic                          out_valid,
    output logic [cicd_pkg::ACC_WIDTH-1:0] node_sum
);

    localparam int GX = cicd_pkg::GRID_BITS_X;
    localparam int GY = cicd_pkg::GRID_BITS_Y;
    localparam int AW = cicd_pkg::NODE_AW;

    logic [cicd_pkg::POS_W-1:0]    x_sat, y_sat;
    logic [GX:0]                   cell_x_raw;
    logic [GY:0]                   cell_y_raw;
    logic [GX-1:0]                 cell_x;
    logic [GY-1:0]                 cell_y;
    logic [cicd_pkg::OFF_X_W-1:0]  fx_in;
    logic [cicd_pkg::OFF_Y_W-1:0]  fy_in;
    logic [AW-1:0]                 base_in;
    logic                          idx_ok_in;

    logic [cicd_pkg::OFF_X_W-1:0]  fx_reg, gx_reg;
    logic [cicd_pkg::OFF_Y_W-1:0]  fy_reg, gy_reg;
    logic [AW-1:0]                 base_reg;
    logic [cicd_pkg::INDEX_W-1:0]  idx_reg;
    logic                          idx_ok_reg;
    logic [cicd_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic [AW-1:0]                 clear_addr_reg, clear_addr_next;
    logic                          out_valid_reg, out_valid_next;
    logic [cicd_pkg::ACC_WIDTH-1:0] node_sum_reg;

    logic                          x_hi, y_hi;
    logic [cicd_pkg::OFF_X_W-1:0]  fac_x;
    logic [cicd_pkg::OFF_Y_W-1:0]  fac_y;
    logic [AW-1:0]                 node_addr;
    logic [cicd_pkg::ACC_WIDTH:0]  acc_sum;
    logic [cicd_pkg::ACC_WIDTH-1:0] acc_sat;

    logic                          ram_wr_en, ram_rd_en;
    logic [AW-1:0]                 ram_wr_addr, ram_rd_addr;
    logic [cicd_pkg::ACC_WIDTH-1:0] ram_wr_data, ram_rd_data;

    // position saturation and cell clamp
    always_comb
    begin
        x_sat      = (pos_x > cicd_pkg::POS_ONE) ? cicd_pkg::POS_ONE : pos_x;
        y_sat      = (pos_y > cicd_pkg::POS_ONE) ? cicd_pkg::POS_ONE : pos_y;
        cell_x_raw = x_sat[cicd_pkg::POS_W-1:cicd_pkg::SHIFT_X];
        cell_y_raw = y_sat[cicd_pkg::POS_W-1:cicd_pkg::SHIFT_Y];
        if (cell_x_raw[GX])
        begin
            cell_x = {GX{1'b1}};
            fx_in  = cicd_pkg::CELL_W;
        end
        else
        begin
            cell_x = cell_x_raw[GX-1:0];
            fx_in  = {1'b0, x_sat[cicd_pkg::SHIFT_X-1:0]};
        end
        if (cell_y_raw[GY])
        begin
            cell_y = {GY{1'b1}};
            fy_in  = cicd_pkg::CELL_H;
        end
        else
        begin
            cell_y = cell_y_raw[GY-1:0];
            fy_in  = {1'b0, y_sat[cicd_pkg::SHIFT_Y-1:0]};
        end
        // row stride is NX+1: j*NX + j + i
        base_in   = AW'({cell_y, {GX{1'b0}}}) + AW'(cell_y) + AW'(cell_x);
        idx_ok_in = (node_index < cicd_pkg::INDEX_W'(cicd_pkg::NODE_COUNT));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fx_reg     <= fx_in;
            gx_reg     <= cicd_pkg::CELL_W - fx_in;
            fy_reg     <= fy_in;
            gy_reg     <= cicd_pkg::CELL_H - fy_in;
            base_reg   <= base_in;
            idx_reg    <= node_index;
            idx_ok_reg <= idx_ok_in;
        end
        if (cmd.rd_node)
        begin
            weight_reg <= weight_next;
        end
        if (cmd.out_load)
        begin
            node_sum_reg <= idx_ok_reg ? ram_rd_data : '0;
        end
    end

    // corner select, weight product and node address
    always_comb
    begin
        x_hi        = (cmd.corner == cicd_pkg::NODE_10) || (cmd.corner == cicd_pkg::NODE_11);
        y_hi        = (cmd.corner == cicd_pkg::NODE_01) || (cmd.corner == cicd_pkg::NODE_11);
        fac_x       = x_hi ? fx_reg : gx_reg;
        fac_y       = y_hi ? fy_reg : gy_reg;
        weight_next = cicd_pkg::WEIGHT_W'(fac_x) * cicd_pkg::WEIGHT_W'(fac_y);
        node_addr   = base_reg + AW'(x_hi) + (y_hi ? AW'(cicd_pkg::ROW_STRIDE) : AW'(0));
        acc_sum     = {1'b0, ram_rd_data} + (cicd_pkg::ACC_WIDTH + 1)'(weight_reg);
        acc_sat     = acc_sum[cicd_pkg::ACC_WIDTH] ? cicd_pkg::ACC_MAX
                                                  : acc_sum[cicd_pkg::ACC_WIDTH-1:0];
    end

    // memory port selection
    always_comb
    begin
        ram_wr_en   = cmd.clear_step || cmd.wr_node || (cmd.out_load && idx_ok_reg);
        ram_rd_en   = cmd.rd_node || (cmd.rd_index && idx_ok_reg);
        ram_rd_addr = cmd.rd_node ? node_addr : AW'(idx_reg);
        priority if (cmd.clear_step)
        begin
            ram_wr_addr = clear_addr_reg;
            ram_wr_data = '0;
        end
        else if (cmd.wr_node)
        begin
            ram_wr_addr = node_addr;
            ram_wr_data = acc_sat;
        end
        else
        begin
            ram_wr_addr = AW'(idx_reg);
            ram_wr_data = '0;
        end
    end

    cicd_ram #(
        .WIDTH (cicd_pkg::ACC_WIDTH),
        .DEPTH (cicd_pkg::NODE_COUNT)
    ) u_mesh (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // clear sweep counter and output word flag
    always_comb
    begin
        clear_addr_next = clear_addr_reg;
        if (cmd.clear_step)
        begin
            clear_addr_next = clear_addr_reg + AW'(1);
        end
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clear_addr_reg <= clear_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign status.clear_last = (clear_addr_reg == AW'(cicd_pkg::NODE_COUNT - 1));
    assign status.out_busy   = out_valid_reg && !out_ready;
    assign out_valid         = out_valid_reg;
    assign node_sum          = node_sum_reg;

endmodule

// File: rtl/core/cicd_ctrl.sv
// ----------------------------------------------------------------------------
// cicd_ctrl
// controller: reset clearing sweep, four-corner read-modify-write sequence
// and read-and-clear sequence
// ----------------------------------------------------------------------------
`include "cloud_in_cell_deposit_unit_macros.svh"

module cicd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               kind,
    input  cicd_pkg::status_t  status,
    output logic               in_ready,
    output cicd_pkg::cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DEP_RD = 6'b000100,
        S_DEP_WR = 6'b001000,
        S_RD_RD  = 6'b010000,
        S_RD_WR  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    cicd_pkg::corner_t  corner_reg, corner_next;
    logic               accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        cmd            = '0;
        cmd.corner     = corner_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load    = 1'b1;
                    corner_next = cicd_pkg::NODE_00;
                    state_next  = (kind == cicd_pkg::KIND_READ) ? S_RD_RD : S_DEP_RD;
                end
            end
            S_DEP_RD:
            begin
                cmd.rd_node = 1'b1;
                state_next  = S_DEP_WR;
            end
            S_DEP_WR:
            begin
                cmd.wr_node = 1'b1;
                unique case (corner_reg)
                    cicd_pkg::NODE_00:
                    begin
                        corner_next = cicd_pkg::NODE_10;
                        state_next  = S_DEP_RD;
                    end
                    cicd_pkg::NODE_10:
                    begin
                        corner_next = cicd_pkg::NODE_01;
                        state_next  = S_DEP_RD;
                    end
                    cicd_pkg::NODE_01:
                    begin
                        corner_next = cicd_pkg::NODE_11;
                        state_next  = S_DEP_RD;
                    end
                    cicd_pkg::NODE_11:
                    begin
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RD_RD:
            begin
                cmd.rd_index = 1'b1;
                state_next   = S_RD_WR;
            end
            S_RD_WR:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            corner_reg <= cicd_pkg::NODE_00;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    `CICD_ASSERT_NEXT(a_deposit_starts, clk, rst_n, accept && (kind == cicd_pkg::KIND_DEPOSIT), (state_reg == S_DEP_RD) && (corner_reg == cicd_pkg::NODE_00), "deposit word did not start at first corner")
    `CICD_ASSERT_NEXT(a_last_corner_ends, clk, rst_n, (state_reg == S_DEP_WR) && (corner_reg == cicd_pkg::NODE_11), state_reg == S_IDLE, "deposit did not end after last corner")
    `CICD_ASSERT_NEXT(a_read_done, clk, rst_n, (state_reg == S_RD_WR) && !status.out_busy, state_reg == S_IDLE, "read word not retired when output free")
    `CICD_ASSERT_SAME(a_no_load_busy, clk, rst_n, cmd.out_load, !status.out_busy, "output word overwritten while waiting")

endmodule
